[rtl/core/bba_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the bitmap buddy allocator.
// Depends on nothing; used by buddy_block_allocator_unit.
package bba_pkg;

    // Default sizing
    localparam int MAX_BLOCKS_DEF      = 4096;
    localparam int MIN_BLOCK_BYTES_DEF = 1024;
    localparam int LEVELS_DEF          = 13;

    // Bitmap memory word
    localparam int BM_WORD     = 32;
    localparam int BM_WORD_LOG = 5;

    // Fixed port widths
    localparam int BC_PORT_W   = 13;
    localparam int ADDR_W      = 48;
    localparam int REQ_W       = 32;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 48;
    localparam int SZL_W       = 6;

    // Request kinds
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 1'd1;

endpackage

[rtl/core/buddy_block_allocator_unit.sv]
`timescale 1ns / 1ps
// Bitmap buddy allocator: one request at a time, a small sequencer driving one
// read-modify-write port on a word-wide bitmap memory. Depends on bba_pkg.
// Allocate: scans the bitmap words of the chosen level, then splits down level by level.
// Free: merges with free buddies level by level. One request in flight; busy meanwhile.
// The result shows for one cycle on o_result_valid; the receiver cannot stall it.
// Reset and each block_count write run a clearing pass over both memories, then
// free the last block of every odd-sized level.
module buddy_block_allocator_unit #(
    parameter int MAX_BLOCKS      = bba_pkg::MAX_BLOCKS_DEF,
    parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF,
    parameter int LEVELS          = bba_pkg::LEVELS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_func,
    input  logic [bba_pkg::REQ_W-1:0]            i_request_size,
    input  logic [bba_pkg::ADDR_W-1:0]           i_free_address,
    output logic                                 o_result_valid,
    output logic                                 o_ok,
    output logic [bba_pkg::STATUS_W-1:0]         o_status,
    output logic [bba_pkg::ADDR_W-1:0]           o_address,
    output logic [bba_pkg::BC_PORT_W-1:0]        o_used_blocks,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bba_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int BW      = bba_pkg::BM_WORD;
    localparam int BWL     = bba_pkg::BM_WORD_LOG;
    localparam int AW      = bba_pkg::ADDR_W;
    localparam int BLK_W   = $clog2(MAX_BLOCKS);
    localparam int BC_W    = $clog2(MAX_BLOCKS + 1);
    localparam int LVL_W   = $clog2(LEVELS + 1);
    localparam int LI_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ROWS    = (2 * MAX_BLOCKS + BW - 1) / BW;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BIDX_W  = ROW_W + BWL;
    localparam int LOG_MIN = $clog2(MIN_BLOCK_BYTES);
    localparam int CLR_N   = (ROWS > MAX_BLOCKS) ? ROWS : MAX_BLOCKS;
    localparam int CLR_W   = $clog2(CLR_N + 1);
    localparam int AL_W    = LVL_W + 1;
    localparam int SZL_W   = bba_pkg::SZL_W;
    localparam int ST_W    = 5;

    // Sequencer states
    localparam logic [ST_W-1:0] S_CLEAR    = 5'd0;
    localparam logic [ST_W-1:0] S_INIT     = 5'd1;
    localparam logic [ST_W-1:0] S_IDLE     = 5'd2;
    localparam logic [ST_W-1:0] S_OP_RD    = 5'd3;
    localparam logic [ST_W-1:0] S_OP_WR    = 5'd4;
    localparam logic [ST_W-1:0] S_A_CHK    = 5'd5;
    localparam logic [ST_W-1:0] S_A_SCRD   = 5'd6;
    localparam logic [ST_W-1:0] S_A_SCCHK  = 5'd7;
    localparam logic [ST_W-1:0] S_A_SPLIT  = 5'd8;
    localparam logic [ST_W-1:0] S_A_SPLIT2 = 5'd9;
    localparam logic [ST_W-1:0] S_A_MARK   = 5'd10;
    localparam logic [ST_W-1:0] S_F_SUB    = 5'd11;
    localparam logic [ST_W-1:0] S_F_CHK    = 5'd12;
    localparam logic [ST_W-1:0] S_F_ACHK   = 5'd13;
    localparam logic [ST_W-1:0] S_F_BUD    = 5'd14;
    localparam logic [ST_W-1:0] S_F_BUDW   = 5'd15;
    localparam logic [ST_W-1:0] S_F_END    = 5'd16;

    // Bit offset of each level's region in the bitmap
    function automatic int f_lvl_base(input int lvl);
        int b;
        b = 0;
        for (int k = 0; k < lvl; k++) begin
            b = b + (MAX_BLOCKS >> k);
        end
        return b;
    endfunction

    logic [BIDX_W-1:0] c_lvl_base [LEVELS];

    for (genvar g = 0; g < LEVELS; g++) begin : g_base
        assign c_lvl_base[g] = BIDX_W'(f_lvl_base(g));
    end

    // Memories
    logic [BW-1:0]   bm_mem [ROWS];
    logic [AL_W-1:0] al_mem [MAX_BLOCKS];

    // Registers
    logic [ST_W-1:0]   r_state, n_state;
    logic [ST_W-1:0]   r_ret, n_ret;
    logic [CLR_W-1:0]  r_clr, n_clr;
    logic [LVL_W-1:0]  r_j, n_j;
    logic [SZL_W-1:0]  r_szl, n_szl;
    logic [LVL_W-1:0]  r_i, n_i;
    logic [BLK_W-1:0]  r_off, n_off;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [LVL_W-1:0]  r_op_lvl, n_op_lvl;
    logic [BLK_W-1:0]  r_op_off, n_op_off;
    logic              r_op_val, n_op_val;
    logic [BIDX_W-1:0] r_bidx, n_bidx;
    logic [BC_W-1:0]   r_cnt [LEVELS];
    logic [BC_W-1:0]   n_cnt [LEVELS];
    logic [BC_W-1:0]   r_used, n_used;
    logic [BC_W-1:0]   r_bc, n_bc;
    logic [AW-1:0]     r_base, n_base;
    logic [AW-1:0]     r_faddr, n_faddr;
    logic [AW-1:0]     r_diff, n_diff;
    logic              r_borrow, n_borrow;
    logic              r_rvld, n_rvld;
    logic              r_ok, n_ok;
    logic [bba_pkg::STATUS_W-1:0] r_status, n_status;
    logic [AW-1:0]     r_addr_out, n_addr_out;
    logic [BC_W-1:0]   r_used_out, n_used_out;
    logic [BW-1:0]     r_bm_rdata;
    logic [AL_W-1:0]   r_al_rdata;

    // Memory port controls
    logic              bm_we;
    logic [ROW_W-1:0]  bm_waddr, bm_raddr;
    logic [BW-1:0]     bm_wdata;
    logic              al_we;
    logic [BLK_W-1:0]  al_waddr, al_raddr;
    logic [AL_W-1:0]   al_wdata;

    // Working values
    logic [LVL_W-1:0]  lt;
    logic [SZL_W-1:0]  req_szl;
    logic [bba_pkg::REQ_W-1:0] req_m1;
    logic [BC_W-1:0]   op_size;
    logic [BIDX_W-1:0] op_bidx;
    logic              op_ok;
    logic              fl_found;
    logic [LVL_W-1:0]  fl_lvl;
    logic [BIDX_W-1:0] sc_lb;
    logic [BIDX_W:0]   sc_hb;
    logic [BW-1:0]     sc_mask;
    logic [BW-1:0]     sc_hit;
    logic [BWL-1:0]    sc_ffs;
    logic [BIDX_W-1:0] sc_idx;
    logic [BLK_W-1:0]  bud_off;
    logic [BC_W-1:0]   bud_size;
    logic              bud_ok;
    logic [BIDX_W-1:0] bud_bidx;
    logic [AW-1:0]     blk_num;
    logic [BLK_W-1:0]  mark_idx;
    logic [BC_W-1:0]   amount;
    logic              old_bit;
    logic [BC_W-1:0]   cfg_bc;

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_rvld;
    assign o_ok           = r_ok;
    assign o_status       = r_status;
    assign o_address      = r_addr_out;
    assign o_used_blocks  = bba_pkg::BC_PORT_W'(r_used_out);

    // Level count: bit length of the block count, capped
    always_comb begin
        int n;
        n = 0;
        for (int b = 0; b < BC_W; b++) begin
            if (r_bc[b]) begin
                n = b + 1;
            end
        end
        if (n > LEVELS) begin
            n = LEVELS;
        end
        lt = LVL_W'(n);
    end

    // Size level of an incoming request: bit length of (size-1)/min block
    always_comb begin
        int n;
        n = 0;
        req_m1 = i_request_size - 1'b1;
        for (int b = LOG_MIN; b < bba_pkg::REQ_W; b++) begin
            if (req_m1[b]) begin
                n = b - LOG_MIN + 1;
            end
        end
        if (i_request_size == '0) begin
            n = 0;
        end
        req_szl = SZL_W'(n);
    end

    // Bit operation target: bitmap index and range check
    always_comb begin
        op_size = r_bc >> r_op_lvl;
        op_bidx = c_lvl_base[r_op_lvl[LI_W-1:0]] + BIDX_W'(r_op_off);
        op_ok   = (r_op_lvl < lt) && (BC_W'(r_op_off) < op_size);
    end

    // Lowest level at or above the size level with a free block
    always_comb begin
        fl_found = 1'b0;
        fl_lvl   = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if ((SZL_W'(l) >= r_szl) && (LVL_W'(l) < lt) && (r_cnt[l] != '0)) begin
                fl_found = 1'b1;
                fl_lvl   = LVL_W'(l);
            end
        end
    end

    // Scan one bitmap word of the chosen level for its first free bit
    always_comb begin
        sc_lb  = c_lvl_base[r_i[LI_W-1:0]];
        sc_hb  = {1'b0, sc_lb} + (BIDX_W + 1)'(r_bc >> r_i);
        sc_ffs = '0;
        for (int b = 0; b < BW; b++) begin
            sc_mask[b] = ({1'b0, r_row, BWL'(b)} >= {1'b0, sc_lb}) &&
                         ({1'b0, r_row, BWL'(b)} < sc_hb);
        end
        sc_hit = r_bm_rdata & sc_mask;
        for (int b = BW - 1; b >= 0; b--) begin
            if (sc_hit[b]) begin
                sc_ffs = BWL'(b);
            end
        end
        sc_idx = {r_row, sc_ffs} - sc_lb;
    end

    // Buddy of the block being freed
    always_comb begin
        bud_off  = r_off ^ BLK_W'(1);
        bud_size = r_bc >> r_i;
        bud_ok   = (r_i < lt) && (BC_W'(bud_off) < bud_size);
        bud_bidx = c_lvl_base[r_i[LI_W-1:0]] + BIDX_W'(bud_off);
    end

    assign blk_num  = r_diff >> LOG_MIN;
    assign mark_idx = r_off << r_szl;
    assign amount   = BC_W'(1) << r_szl;
    assign old_bit  = r_bm_rdata[r_bidx[BWL-1:0]];
    assign cfg_bc   = (i_cfg_data[bba_pkg::BC_PORT_W-1:0] > bba_pkg::BC_PORT_W'(MAX_BLOCKS))
                      ? BC_W'(MAX_BLOCKS) : BC_W'(i_cfg_data[bba_pkg::BC_PORT_W-1:0]);

    // Sequencer next state
    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_clr      = r_clr;
        n_j        = r_j;
        n_szl      = r_szl;
        n_i        = r_i;
        n_off      = r_off;
        n_row      = r_row;
        n_op_lvl   = r_op_lvl;
        n_op_off   = r_op_off;
        n_op_val   = r_op_val;
        n_bidx     = r_bidx;
        n_cnt      = r_cnt;
        n_used     = r_used;
        n_bc       = r_bc;
        n_base     = r_base;
        n_faddr    = r_faddr;
        n_diff     = r_diff;
        n_borrow   = r_borrow;
        n_rvld     = 1'b0;
        n_ok       = r_ok;
        n_status   = r_status;
        n_addr_out = r_addr_out;
        n_used_out = r_used_out;
        bm_we      = 1'b0;
        bm_waddr   = r_bidx[BIDX_W-1:BWL];
        bm_wdata   = r_bm_rdata;
        bm_raddr   = r_row;
        al_we      = 1'b0;
        al_waddr   = r_off;
        al_wdata   = '0;
        al_raddr   = r_off;

        unique case (r_state)
            // Wipe both memories, one row and one entry a cycle
            S_CLEAR: begin
                bm_waddr = r_clr[ROW_W-1:0];
                bm_wdata = '0;
                bm_we    = (r_clr < CLR_W'(ROWS));
                al_waddr = r_clr[BLK_W-1:0];
                al_we    = (r_clr < CLR_W'(MAX_BLOCKS));
                if (r_clr == CLR_W'(CLR_N - 1)) begin
                    n_state = S_INIT;
                    n_j     = '0;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            // Free the last block of every odd-sized level
            S_INIT: begin
                if (r_j >= lt) begin
                    n_state = S_IDLE;
                end else begin
                    n_j = r_j + 1'b1;
                    if (r_bc[r_j]) begin
                        n_op_lvl = r_j;
                        n_op_off = BLK_W'((r_bc >> r_j) - 1'b1);
                        n_op_val = 1'b1;
                        n_ret    = S_INIT;
                        n_state  = S_OP_RD;
                    end
                end
            end
            // Take a request
            S_IDLE: begin
                if (start) begin
                    if (i_func == bba_pkg::FUNC_ALLOC) begin
                        n_szl   = req_szl;
                        n_state = S_A_CHK;
                    end else begin
                        n_faddr = i_free_address;
                        n_state = S_F_SUB;
                    end
                end
            end
            // Read the word holding the target bit
            S_OP_RD: begin
                if (op_ok) begin
                    bm_raddr = op_bidx[BIDX_W-1:BWL];
                    n_bidx   = op_bidx;
                    n_state  = S_OP_WR;
                end else begin
                    n_state = r_ret;
                end
            end
            // Write the target bit back and keep the level count
            S_OP_WR: begin
                bm_wdata                   = r_bm_rdata;
                bm_wdata[r_bidx[BWL-1:0]]  = r_op_val;
                bm_we                      = 1'b1;
                if (r_op_val && !old_bit) begin
                    n_cnt[r_op_lvl[LI_W-1:0]] = r_cnt[r_op_lvl[LI_W-1:0]] + 1'b1;
                end else if (!r_op_val && old_bit) begin
                    n_cnt[r_op_lvl[LI_W-1:0]] = r_cnt[r_op_lvl[LI_W-1:0]] - 1'b1;
                end
                n_state = r_ret;
            end
            // Check size, space and pick the level to take from
            S_A_CHK: begin
                priority if ({{(bba_pkg::REQ_W - SZL_W){1'b0}}, r_szl} >=
                             bba_pkg::REQ_W'(lt)) begin
                    n_ok = 1'b0; n_status = bba_pkg::ST_TOO_LARGE;
                    n_addr_out = '0; n_used_out = r_used;
                    n_rvld = 1'b1; n_state = S_IDLE;
                end else if ((bba_pkg::REQ_W'(r_used) + (bba_pkg::REQ_W'(1) << r_szl))
                             > bba_pkg::REQ_W'(r_bc) || !fl_found) begin
                    n_ok = 1'b0; n_status = bba_pkg::ST_NO_SPACE;
                    n_addr_out = '0; n_used_out = r_used;
                    n_rvld = 1'b1; n_state = S_IDLE;
                end else begin
                    n_i     = fl_lvl;
                    n_row   = c_lvl_base[fl_lvl[LI_W-1:0]][BIDX_W-1:BWL];
                    n_state = S_A_SCRD;
                end
            end
            S_A_SCRD: begin
                bm_raddr = r_row;
                n_state  = S_A_SCCHK;
            end
            // Take the first free bit, or advance to the next word
            S_A_SCCHK: begin
                if (sc_hit != '0) begin
                    n_off    = BLK_W'(sc_idx);
                    n_op_lvl = r_i;
                    n_op_off = BLK_W'(sc_idx);
                    n_op_val = 1'b0;
                    n_ret    = S_A_SPLIT;
                    n_state  = S_OP_RD;
                end else if (({1'b0, r_row, {BWL{1'b1}}} + 1'b1) >= sc_hb) begin
                    n_ok = 1'b0; n_status = bba_pkg::ST_NO_SPACE;
                    n_addr_out = '0; n_used_out = r_used;
                    n_rvld = 1'b1; n_state = S_IDLE;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = S_A_SCRD;
                end
            end
            // Split down: left half taken, right half freed
            S_A_SPLIT: begin
                if (SZL_W'(r_i) > r_szl) begin
                    n_op_lvl = r_i - 1'b1;
                    n_op_off = r_off << 1;
                    n_op_val = 1'b0;
                    n_ret    = S_A_SPLIT2;
                    n_state  = S_OP_RD;
                end else begin
                    n_state = S_A_MARK;
                end
            end
            S_A_SPLIT2: begin
                n_op_lvl = r_i - 1'b1;
                n_op_off = (r_off << 1) | BLK_W'(1);
                n_op_val = 1'b1;
                n_off    = r_off << 1;
                n_i      = r_i - 1'b1;
                n_ret    = S_A_SPLIT;
                n_state  = S_OP_RD;
            end
            // Record the level at the block and answer
            S_A_MARK: begin
                al_we      = 1'b1;
                al_waddr   = mark_idx;
                al_wdata   = {1'b1, LVL_W'(r_szl)};
                n_used     = r_used + amount;
                n_ok       = 1'b1;
                n_status   = bba_pkg::ST_OK;
                n_addr_out = r_base + (AW'(mark_idx) << LOG_MIN);
                n_used_out = r_used + amount;
                n_rvld     = 1'b1;
                n_state    = S_IDLE;
            end
            S_F_SUB: begin
                n_diff   = r_faddr - r_base;
                n_borrow = (r_faddr < r_base);
                n_state  = S_F_CHK;
            end
            // Range check and fetch the stored level
            S_F_CHK: begin
                if (r_borrow || (blk_num >= AW'(r_bc))) begin
                    n_ok = 1'b0; n_status = bba_pkg::ST_RANGE;
                    n_addr_out = '0; n_used_out = r_used;
                    n_rvld = 1'b1; n_state = S_IDLE;
                end else begin
                    n_off    = blk_num[BLK_W-1:0];
                    al_raddr = blk_num[BLK_W-1:0];
                    n_state  = S_F_ACHK;
                end
            end
            S_F_ACHK: begin
                if (!r_al_rdata[LVL_W] || (r_al_rdata[LVL_W-1:0] >= lt)) begin
                    n_ok = 1'b0; n_status = bba_pkg::ST_NOT_ALLOC;
                    n_addr_out = '0; n_used_out = r_used;
                    n_rvld = 1'b1; n_state = S_IDLE;
                end else begin
                    al_we    = 1'b1;
                    al_waddr = r_off;
                    al_wdata = '0;
                    n_szl    = SZL_W'(r_al_rdata[LVL_W-1:0]);
                    n_i      = r_al_rdata[LVL_W-1:0];
                    n_off    = r_off >> r_al_rdata[LVL_W-1:0];
                    n_state  = S_F_BUD;
                end
            end
            // Read the buddy, or set the block free when it has none
            S_F_BUD: begin
                if (bud_ok) begin
                    bm_raddr = bud_bidx[BIDX_W-1:BWL];
                    n_bidx   = bud_bidx;
                    n_state  = S_F_BUDW;
                end else begin
                    n_op_lvl = r_i;
                    n_op_off = r_off;
                    n_op_val = 1'b1;
                    n_ret    = S_F_END;
                    n_state  = S_OP_RD;
                end
            end
            // Merge with a free buddy and climb, else set the block free
            S_F_BUDW: begin
                if (old_bit) begin
                    bm_wdata                  = r_bm_rdata;
                    bm_wdata[r_bidx[BWL-1:0]] = 1'b0;
                    bm_we                     = 1'b1;
                    n_cnt[r_i[LI_W-1:0]]      = r_cnt[r_i[LI_W-1:0]] - 1'b1;
                    n_off                     = r_off >> 1;
                    n_i                       = r_i + 1'b1;
                    n_state = ((r_i + 1'b1) < lt) ? S_F_BUD : S_F_END;
                end else begin
                    n_op_lvl = r_i;
                    n_op_off = r_off;
                    n_op_val = 1'b1;
                    n_ret    = S_F_END;
                    n_state  = S_OP_RD;
                end
            end
            S_F_END: begin
                n_used     = (r_used >= amount) ? (r_used - amount) : '0;
                n_ok       = 1'b1;
                n_status   = bba_pkg::ST_OK;
                n_addr_out = '0;
                n_used_out = (r_used >= amount) ? (r_used - amount) : '0;
                n_rvld     = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Configuration writes; a block count restarts the clearing pass
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bba_pkg::CFG_BLOCK_COUNT: begin
                    n_bc    = cfg_bc;
                    n_state = S_CLEAR;
                    n_clr   = '0;
                    n_used  = '0;
                    for (int l = 0; l < LEVELS; l++) begin
                        n_cnt[l] = '0;
                    end
                end
                bba_pkg::CFG_POOL_BASE: begin
                    n_base = i_cfg_data[AW-1:0];
                end
                default: begin
                    n_base = r_base;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_j      <= '0;
            r_bc     <= BC_W'(MAX_BLOCKS);
            r_base   <= '0;
            r_used   <= '0;
            r_rvld   <= 1'b0;
            r_ret    <= S_IDLE;
            for (int l = 0; l < LEVELS; l++) begin
                r_cnt[l] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_j      <= n_j;
            r_bc     <= n_bc;
            r_base   <= n_base;
            r_used   <= n_used;
            r_rvld   <= n_rvld;
            r_ret    <= n_ret;
            r_cnt    <= n_cnt;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_szl      <= n_szl;
        r_i        <= n_i;
        r_off      <= n_off;
        r_row      <= n_row;
        r_op_lvl   <= n_op_lvl;
        r_op_off   <= n_op_off;
        r_op_val   <= n_op_val;
        r_bidx     <= n_bidx;
        r_faddr    <= n_faddr;
        r_diff     <= n_diff;
        r_borrow   <= n_borrow;
        r_ok       <= n_ok;
        r_status   <= n_status;
        r_addr_out <= n_addr_out;
        r_used_out <= n_used_out;
    end

    // Bitmap memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        r_bm_rdata <= bm_mem[bm_raddr];
    end

    // Allocation level memory: valid bit and level per minimum block
    always_ff @(posedge i_clk) begin
        if (al_we) begin
            al_mem[al_waddr] <= al_wdata;
        end
        r_al_rdata <= al_mem[al_raddr];
    end

endmodule
